>>> hdl/scra_pkg.sv
// shared constants and types for the square crop rotate address block
package scra_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_BITS   = $clog2(MAX_DIM);
    localparam int SIZE_BITS  = DIM_BITS + 1;
    localparam int PIXEL_BITS = 24;
    localparam int INDEX_BITS = 24;
    localparam int CFG_BITS   = 3;

    localparam logic [CFG_BITS-1:0] CFG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_BITS-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_BITS-1:0] CFG_SIDE_LENGTH    = 3'd2;
    localparam logic [CFG_BITS-1:0] CFG_CROP_COL_START = 3'd3;
    localparam logic [CFG_BITS-1:0] CFG_CROP_ROW_START = 3'd4;
    localparam logic [CFG_BITS-1:0] CFG_ORIENTATION    = 3'd5;

    typedef enum logic [1:0] {
        ORIENT_IDENT     = 2'd0,
        ORIENT_TRANSPOSE = 2'd1,
        ORIENT_ROT180    = 2'd2,
        ORIENT_ANTI      = 2'd3
    } t_orient;

    // window settings handed to the window stage
    typedef struct packed {
        logic [SIZE_BITS-1:0] side;
        logic [DIM_BITS-1:0]  col_start;
        logic [DIM_BITS-1:0]  row_start;
        t_orient              orient;
    } t_win_cfg;

endpackage

>>> hdl/scra_raster.sv
// input register stage with the raster row and column counters
module scra_raster import scra_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    output logic                  o_ready,
    input  logic [SIZE_BITS-1:0]  i_width,
    input  logic [SIZE_BITS-1:0]  i_height,
    output logic                  o_valid,
    output logic [PIXEL_BITS-1:0] o_pixel,
    output logic [DIM_BITS-1:0]   o_row,
    output logic [DIM_BITS-1:0]   o_col,
    input  logic                  i_ready
);

    logic                  r_valid;
    logic [PIXEL_BITS-1:0] r_pixel;
    logic [DIM_BITS-1:0]   r_row;
    logic [DIM_BITS-1:0]   r_col;
    logic [DIM_BITS-1:0]   r_row_count;
    logic [DIM_BITS-1:0]   r_col_count;
    logic [DIM_BITS-1:0]   n_row_count;
    logic [DIM_BITS-1:0]   n_col_count;
    logic [SIZE_BITS-1:0]  col_inc;
    logic [SIZE_BITS-1:0]  row_inc;
    logic                  accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign col_inc = {1'b0, r_col_count} + 1'b1;
    assign row_inc = {1'b0, r_row_count} + 1'b1;

    always_comb begin
        if (col_inc >= i_width) begin
            n_col_count = '0;
            n_row_count = (row_inc >= i_height) ? '0 : row_inc[DIM_BITS-1:0];
        end else begin
            n_col_count = col_inc[DIM_BITS-1:0];
            n_row_count = r_row_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_row_count <= '0;
            r_col_count <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_row_count <= n_row_count;
                r_col_count <= n_col_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel <= i_pixel;
            r_row   <= r_row_count;
            r_col   <= r_col_count;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_row   = r_row;
    assign o_col   = r_col;

endmodule

>>> hdl/scra_window.sv
// window test and orientation mapping stage
module scra_window import scra_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_win_cfg              i_cfg,
    input  logic                  i_valid,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  logic [DIM_BITS-1:0]   i_row,
    input  logic [DIM_BITS-1:0]   i_col,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic [PIXEL_BITS-1:0] o_pixel,
    output logic [DIM_BITS-1:0]   o_row,
    output logic [DIM_BITS-1:0]   o_col,
    input  logic                  i_ready
);

    logic                  r_valid;
    logic [PIXEL_BITS-1:0] r_pixel;
    logic [DIM_BITS-1:0]   r_row;
    logic [DIM_BITS-1:0]   r_col;
    logic [DIM_BITS-1:0]   n_row;
    logic [DIM_BITS-1:0]   n_col;
    logic [DIM_BITS-1:0]   dr;
    logic [DIM_BITS-1:0]   dc;
    logic [DIM_BITS-1:0]   last;
    logic                  in_win;
    logic                  accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign dr   = i_row - i_cfg.row_start;
    assign dc   = i_col - i_cfg.col_start;
    // side of 4096 wraps to 0 here, so last lands on 4095
    assign last = i_cfg.side[DIM_BITS-1:0] - 1'b1;

    assign in_win = (i_cfg.side != '0)
                 && (i_row >= i_cfg.row_start) && (i_col >= i_cfg.col_start)
                 && ({1'b0, dr} < i_cfg.side) && ({1'b0, dc} < i_cfg.side);

    always_comb begin
        unique case (i_cfg.orient)
            ORIENT_IDENT: begin
                n_row = dr;
                n_col = dc;
            end
            ORIENT_TRANSPOSE: begin
                n_row = dc;
                n_col = dr;
            end
            ORIENT_ROT180: begin
                n_row = last - dr;
                n_col = last - dc;
            end
            default: begin
                n_row = last - dc;
                n_col = last - dr;
            end
        endcase
    end

    // beats outside the window are dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && in_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel <= i_pixel;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_row   = r_row;
    assign o_col   = r_col;

    a_row_in_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_row} < i_cfg.side))
        else $error("destination row outside crop side");

    a_col_in_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_col} < i_cfg.side))
        else $error("destination column outside crop side");

    a_no_side_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.side == '0) && $stable(i_cfg.side) && !$past(r_valid) |-> !r_valid)
        else $error("beat passed with empty window");

endmodule

>>> hdl/scra_index.sv
// linear index multiply and output register stage
module scra_index import scra_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [SIZE_BITS-1:0]  i_side,
    input  logic                  i_valid,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  logic [DIM_BITS-1:0]   i_row,
    input  logic [DIM_BITS-1:0]   i_col,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic [PIXEL_BITS-1:0] o_pixel,
    output logic [DIM_BITS-1:0]   o_row,
    output logic [DIM_BITS-1:0]   o_col,
    output logic [INDEX_BITS-1:0] o_index,
    input  logic                  i_ready
);

    localparam int PROD_BITS = DIM_BITS + SIZE_BITS;

    logic                  r_valid;
    logic [PIXEL_BITS-1:0] r_pixel;
    logic [DIM_BITS-1:0]   r_row;
    logic [DIM_BITS-1:0]   r_col;
    logic [INDEX_BITS-1:0] r_index;
    logic [INDEX_BITS-1:0] n_index;
    logic [PROD_BITS-1:0]  prod;
    logic                  accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign prod    = {{SIZE_BITS{1'b0}}, i_row} * {{DIM_BITS{1'b0}}, i_side};
    assign n_index = prod[INDEX_BITS-1:0] + {{(INDEX_BITS-DIM_BITS){1'b0}}, i_col};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel <= i_pixel;
            r_row   <= i_row;
            r_col   <= i_col;
            r_index <= n_index;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;
    assign o_row   = r_row;
    assign o_col   = r_col;
    assign o_index = r_index;

    a_identity_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_row == '0) |=> (r_index == {{(INDEX_BITS-DIM_BITS){1'b0}}, r_col}))
        else $error("index of top row differs from column");

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_index))
        else $error("stalled index changed");

endmodule

>>> hdl/square_crop_rotate_address.sv
// top level: configuration registers and the three stage crop pipeline
//
// Pixels enter on the s_axis channel in raster order, one beat per pixel.
// A row and a column counter follow the raster and wrap at the configured
// image width and height. Pixels inside the square crop window leave on the
// m_axis channel with their rotated destination row, column and linear
// index; pixels outside the window produce no beat.
// Throughput is one pixel per clock while the receiver takes beats; the row
// times side multiply and the column add sit together in the last stage.
// Each stage has its own valid register and is refilled while its result is
// being taken, so a stalled receiver only back-pressures once every stage
// holds a beat; s_axis_tready then drops until m_axis_tready returns.
// Synchronous reset empties the pipeline, clears both counters and loads the
// registers with width, height and side 4096, start 0 and identity rotation.
// Configuration writes land on the next edge; write only while no pixel is
// in flight. Width and height of 0 act as 1; a side of 0 gives no output
// beat; sizes above 4096 act as 4096.
module square_crop_rotate_address import scra_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // pixel_in[23:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pixel_out[23:0], dest_row[35:24], dest_col[47:36], dest_index[71:48]
    output logic [71:0]           m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_BITS-1:0]   i_cfg_index,
    input  logic [SIZE_BITS-1:0]  i_cfg_data
);

    logic [SIZE_BITS-1:0] r_image_width;
    logic [SIZE_BITS-1:0] r_image_height;
    logic [SIZE_BITS-1:0] r_side_length;
    logic [DIM_BITS-1:0]  r_crop_col_start;
    logic [DIM_BITS-1:0]  r_crop_row_start;
    t_orient              r_orientation;

    logic [SIZE_BITS-1:0] width_eff;
    logic [SIZE_BITS-1:0] height_eff;
    logic [SIZE_BITS-1:0] side_eff;
    t_win_cfg             win_cfg;

    logic                  ras_valid, ras_ready;
    logic [PIXEL_BITS-1:0] ras_pixel;
    logic [DIM_BITS-1:0]   ras_row, ras_col;
    logic                  win_valid, win_ready;
    logic [PIXEL_BITS-1:0] win_pixel;
    logic [DIM_BITS-1:0]   win_row, win_col;
    logic [PIXEL_BITS-1:0] out_pixel;
    logic [DIM_BITS-1:0]   out_row, out_col;
    logic [INDEX_BITS-1:0] out_index;

    localparam logic [SIZE_BITS-1:0] SIZE_MAX = SIZE_BITS'(MAX_DIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width    <= SIZE_MAX;
            r_image_height   <= SIZE_MAX;
            r_side_length    <= SIZE_MAX;
            r_crop_col_start <= '0;
            r_crop_row_start <= '0;
            r_orientation    <= ORIENT_IDENT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:    r_image_width    <= i_cfg_data;
                CFG_IMAGE_HEIGHT:   r_image_height   <= i_cfg_data;
                CFG_SIDE_LENGTH:    r_side_length    <= i_cfg_data;
                CFG_CROP_COL_START: r_crop_col_start <= i_cfg_data[DIM_BITS-1:0];
                CFG_CROP_ROW_START: r_crop_row_start <= i_cfg_data[DIM_BITS-1:0];
                CFG_ORIENTATION:    r_orientation    <= t_orient'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // zero acts as one for the wrap sizes, everything saturates at the max
    always_comb begin
        if (r_image_width == '0) begin
            width_eff = SIZE_BITS'(1);
        end else if (r_image_width > SIZE_MAX) begin
            width_eff = SIZE_MAX;
        end else begin
            width_eff = r_image_width;
        end
        if (r_image_height == '0) begin
            height_eff = SIZE_BITS'(1);
        end else if (r_image_height > SIZE_MAX) begin
            height_eff = SIZE_MAX;
        end else begin
            height_eff = r_image_height;
        end
        side_eff = (r_side_length > SIZE_MAX) ? SIZE_MAX : r_side_length;
    end

    assign win_cfg.side      = side_eff;
    assign win_cfg.col_start = r_crop_col_start;
    assign win_cfg.row_start = r_crop_row_start;
    assign win_cfg.orient    = r_orientation;

    scra_raster u_raster (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_pixel  (s_axis_tdata),
        .o_ready  (s_axis_tready),
        .i_width  (width_eff),
        .i_height (height_eff),
        .o_valid  (ras_valid),
        .o_pixel  (ras_pixel),
        .o_row    (ras_row),
        .o_col    (ras_col),
        .i_ready  (ras_ready)
    );

    scra_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (win_cfg),
        .i_valid (ras_valid),
        .i_pixel (ras_pixel),
        .i_row   (ras_row),
        .i_col   (ras_col),
        .o_ready (ras_ready),
        .o_valid (win_valid),
        .o_pixel (win_pixel),
        .o_row   (win_row),
        .o_col   (win_col),
        .i_ready (win_ready)
    );

    scra_index u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (side_eff),
        .i_valid (win_valid),
        .i_pixel (win_pixel),
        .i_row   (win_row),
        .i_col   (win_col),
        .o_ready (win_ready),
        .o_valid (m_axis_tvalid),
        .o_pixel (out_pixel),
        .o_row   (out_row),
        .o_col   (out_col),
        .o_index (out_index),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {out_index, out_col, out_row, out_pixel};

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    a_out_in_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ({1'b0, out_row} < side_eff) && ({1'b0, out_col} < side_eff))
        else $error("output position outside crop side");

endmodule

>>> bench/testbench.sv
// self-checking bench for the square crop rotate address block
module testbench import scra_pkg::*; ();

    localparam int PIPE_LATENCY = 3;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 2;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD = 300;
    localparam int FAR_RUN = 40;
    localparam logic [CFG_BITS-1:0] CFG_NO_REG = 3'd7;

    // one output beat, laid out as m_axis_tdata from the highest bit down
    typedef struct packed {
        logic [INDEX_BITS-1:0] dest_index;
        logic [DIM_BITS-1:0]   dest_col;
        logic [DIM_BITS-1:0]   dest_row;
        logic [PIXEL_BITS-1:0] pixel;
    } t_crop_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;   // pixel_in[23:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // pixel_out[23:0], dest_row[35:24], dest_col[47:36], dest_index[71:48]
    logic [71:0]          m_axis_tdata;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_BITS-1:0]  i_cfg_index = '0;
    logic [SIZE_BITS-1:0] i_cfg_data = '0;

    // predictor copy of the registers and the raster position
    int      cfg_width = MAX_DIM;
    int      cfg_height = MAX_DIM;
    int      cfg_side = MAX_DIM;
    int      cfg_col_start = 0;
    int      cfg_row_start = 0;
    t_orient cfg_orient = ORIENT_IDENT;
    int      raster_row = 0;
    int      raster_col = 0;

    t_crop_beat crop_beats_due[$];
    int n_errors = 0;
    int quiet_cycles = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_req = 0;

    square_crop_rotate_address DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // works out the crop beat of one source pixel and steps the raster position
    function automatic void predict_crop(input logic [23:0] px);
        int w, h, side, dr, dc, far_pos, orow, ocol;
        t_crop_beat beat;
        w = (cfg_width == 0) ? 1 : (cfg_width > MAX_DIM ? MAX_DIM : cfg_width);
        h = (cfg_height == 0) ? 1 : (cfg_height > MAX_DIM ? MAX_DIM : cfg_height);
        side = (cfg_side > MAX_DIM) ? MAX_DIM : cfg_side;
        dr = raster_row - cfg_row_start;
        dc = raster_col - cfg_col_start;
        if (side != 0 && dr >= 0 && dc >= 0 && dr < side && dc < side) begin
            far_pos = side - 1;
            case (cfg_orient)
                ORIENT_IDENT: begin
                    orow = dr;
                    ocol = dc;
                end
                ORIENT_TRANSPOSE: begin
                    orow = dc;
                    ocol = dr;
                end
                ORIENT_ROT180: begin
                    orow = far_pos - dr;
                    ocol = far_pos - dc;
                end
                default: begin
                    orow = far_pos - dc;
                    ocol = far_pos - dr;
                end
            endcase
            beat.pixel = px;
            beat.dest_row = DIM_BITS'(orow);
            beat.dest_col = DIM_BITS'(ocol);
            beat.dest_index = INDEX_BITS'(orow * side + ocol);
            crop_beats_due.push_back(beat);
        end
        // a counter already past a shrunk size wraps on this step
        if (raster_col + 1 >= w) begin
            raster_col = 0;
            raster_row = (raster_row + 1 >= h) ? 0 : raster_row + 1;
        end else begin
            raster_col = raster_col + 1;
        end
    endfunction

    task automatic write_reg(input logic [CFG_BITS-1:0] idx, input logic [SIZE_BITS-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_IMAGE_WIDTH:    cfg_width = int'(data);
            CFG_IMAGE_HEIGHT:   cfg_height = int'(data);
            CFG_SIDE_LENGTH:    cfg_side = int'(data);
            CFG_CROP_COL_START: cfg_col_start = int'(data[DIM_BITS-1:0]);
            CFG_CROP_ROW_START: cfg_row_start = int'(data[DIM_BITS-1:0]);
            CFG_ORIENTATION:    cfg_orient = t_orient'(data[1:0]);
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(input logic [23:0] px);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_crop(px);
    endtask

    // stop sending, let every crop beat come out, then let outside pixels flush
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (crop_beats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_traffic(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    task automatic compare_field(input string name, input logic [23:0] want,
                                 input logic [23:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            n_errors++;
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req != 0) begin
                hold = rx_hold_req;
                rx_hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_crop_beat want_beat, got_beat;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_beat = m_axis_tdata;
            if (crop_beats_due.size() == 0) begin
                $error("output beat with no pixel waiting for it: %h", m_axis_tdata);
                n_errors++;
            end else begin
                want_beat = crop_beats_due.pop_front();
                compare_field("pixel_out", want_beat.pixel, got_beat.pixel);
                compare_field("dest_row", 24'(want_beat.dest_row), 24'(got_beat.dest_row));
                compare_field("dest_col", 24'(want_beat.dest_col), 24'(got_beat.dest_col));
                compare_field("dest_index", want_beat.dest_index, got_beat.dest_index);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        set_traffic(0, 0);
        // reset values: full 4096 window, identity
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        wait_idle();
        // zero sizes act as one, so the raster wraps back to the origin and stays there
        write_reg(CFG_IMAGE_WIDTH, 13'd0);
        write_reg(CFG_IMAGE_HEIGHT, 13'd0);
        send_pixel(24'hA5A5A5);
        send_pixel(24'h5A5A5A);
        wait_idle();
        // at full side, rotate 180 and anti reach the largest row, column and index
        write_reg(CFG_ORIENTATION, 13'(ORIENT_ROT180));
        send_pixel(24'hFFFFFF);
        wait_idle();
        write_reg(CFG_ORIENTATION, 13'(ORIENT_ANTI));
        send_pixel(24'h800001);
        wait_idle();
        write_reg(CFG_ORIENTATION, 13'(ORIENT_TRANSPOSE));
        send_pixel(24'h7FFFFE);
        wait_idle();
        // oversize image, empty window
        write_reg(CFG_IMAGE_WIDTH, 13'h1FFF);
        write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
        write_reg(CFG_SIDE_LENGTH, 13'd0);
        repeat (3) send_pixel(24'($urandom));
        wait_idle();
        // shrink the width so the current column lies past it; upper start bit is dropped
        write_reg(CFG_SIDE_LENGTH, 13'd2);
        write_reg(CFG_CROP_COL_START, 13'h1002);
        write_reg(CFG_CROP_ROW_START, 13'd0);
        write_reg(CFG_ORIENTATION, 13'h1FFD);
        write_reg(CFG_IMAGE_WIDTH, 13'd3);
        repeat (6) send_pixel(24'($urandom));
        wait_idle();
        // a write to an index with no register behind it changes nothing
        write_reg(CFG_NO_REG, 13'h1FFF);
        repeat (2) send_pixel(24'($urandom));
        wait_idle();
    endtask

    task automatic test_far_edges();
        set_traffic(0, 0);
        // oversize row and oversize side, transposed window from the left edge
        write_reg(CFG_IMAGE_WIDTH, 13'h1FFF);
        write_reg(CFG_IMAGE_HEIGHT, 13'd0);
        write_reg(CFG_SIDE_LENGTH, 13'd8000);
        write_reg(CFG_CROP_COL_START, 13'd0);
        write_reg(CFG_CROP_ROW_START, 13'd0);
        write_reg(CFG_ORIENTATION, 13'(ORIENT_TRANSPOSE));
        repeat (FAR_RUN) send_pixel(24'($urandom));
        wait_idle();
        // one column image, small window partway down
        write_reg(CFG_IMAGE_WIDTH, 13'd0);
        write_reg(CFG_IMAGE_HEIGHT, 13'd4096);
        write_reg(CFG_SIDE_LENGTH, 13'd2);
        write_reg(CFG_CROP_COL_START, 13'd0);
        write_reg(CFG_CROP_ROW_START, 13'd20);
        write_reg(CFG_ORIENTATION, 13'(ORIENT_ANTI));
        repeat (FAR_RUN) send_pixel(24'($urandom));
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_traffic(0, 0);
        write_reg(CFG_IMAGE_WIDTH, 13'd6);
        write_reg(CFG_IMAGE_HEIGHT, 13'd5);
        write_reg(CFG_SIDE_LENGTH, 13'd5);
        write_reg(CFG_CROP_COL_START, 13'd1);
        write_reg(CFG_CROP_ROW_START, 13'd0);
        write_reg(CFG_ORIENTATION, 13'(ORIENT_IDENT));
        // pipeline fills behind the held receiver and stalls the input
        rx_hold_req = LONG_HOLD;
        repeat (60) send_pixel(24'($urandom));
        // sender pauses until the last crop beat is out
        wait_idle();
        repeat (40) send_pixel(24'($urandom));
        wait_idle();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 16; phase++) begin
            case (phase % 4)
                0: set_traffic(0, 0);
                1: set_traffic(71, 0);
                2: set_traffic(0, 71);
                default: set_traffic(15, 15);
            endcase
            case ($urandom_range(9))
                0: write_reg(CFG_IMAGE_WIDTH, 13'd0);
                1: write_reg(CFG_IMAGE_WIDTH, 13'h1FFF);
                2: write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(8191)));
                default: write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(1, 24)));
            endcase
            case ($urandom_range(9))
                0: write_reg(CFG_IMAGE_HEIGHT, 13'd0);
                1: write_reg(CFG_IMAGE_HEIGHT, 13'd4096);
                2: write_reg(CFG_IMAGE_HEIGHT, 13'($urandom_range(8191)));
                default: write_reg(CFG_IMAGE_HEIGHT, 13'($urandom_range(1, 24)));
            endcase
            case ($urandom_range(9))
                0: write_reg(CFG_SIDE_LENGTH, 13'd0);
                1: write_reg(CFG_SIDE_LENGTH, 13'h1FFF);
                2: write_reg(CFG_SIDE_LENGTH, 13'd4096);
                default: write_reg(CFG_SIDE_LENGTH, 13'($urandom_range(1, 16)));
            endcase
            case ($urandom_range(9))
                0: write_reg(CFG_CROP_COL_START, 13'd4095);
                1: write_reg(CFG_CROP_COL_START, 13'($urandom_range(8191)));
                default: write_reg(CFG_CROP_COL_START, 13'($urandom_range(0, 12)));
            endcase
            case ($urandom_range(9))
                0: write_reg(CFG_CROP_ROW_START, 13'd4095);
                1: write_reg(CFG_CROP_ROW_START, 13'($urandom_range(8191)));
                default: write_reg(CFG_CROP_ROW_START, 13'($urandom_range(0, 12)));
            endcase
            write_reg(CFG_ORIENTATION, 13'($urandom_range(8191)));
            repeat ($urandom_range(45, 100)) send_pixel(24'($urandom));
            wait_idle();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_far_edges();
        test_backpressure();
        test_random();
        wait_idle();
        if (n_errors == 0 && crop_beats_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
